@@ src/ehp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the Ethernet/IPv4/TCP/UDP header parser.
// No dependencies.
package ehp_pkg;

    localparam int POS_W = 7;

    localparam logic [POS_W-1:0] POS_MAX      = 7'd127;
    localparam logic [POS_W-1:0] ETH_HDR_END  = 7'd14;
    localparam logic [POS_W-1:0] IP_HDR_END   = 7'd34;
    localparam logic [5:0]       IP_HDR_MIN   = 6'd20;
    localparam logic [7:0]       TCP_HDR_LEN  = 8'd20;
    localparam logic [7:0]       UDP_HDR_LEN  = 8'd8;

    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4 = 4'd4;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    localparam logic [2:0] REC_ETH   = 3'd0;
    localparam logic [2:0] REC_IPV4  = 3'd1;
    localparam logic [2:0] REC_TCP   = 3'd2;
    localparam logic [2:0] REC_UDP   = 3'd3;
    localparam logic [2:0] REC_OTHER = 3'd4;
    localparam logic [2:0] REC_ERROR = 3'd5;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_SHORT_ETH   = 3'd1;
    localparam logic [2:0] ERR_SHORT_IPV4  = 3'd2;
    localparam logic [2:0] ERR_BAD_VERSION = 3'd3;
    localparam logic [2:0] ERR_BAD_IHL     = 3'd4;
    localparam logic [2:0] ERR_SHORT_IHL   = 3'd5;
    localparam logic [2:0] ERR_SHORT_TCP   = 3'd6;
    localparam logic [2:0] ERR_SHORT_UDP   = 3'd7;

    typedef struct packed {
        logic [2:0]  record;
        logic [2:0]  error_code;
        logic [47:0] source_field;
        logic [47:0] dest_field;
        logic [15:0] length_or_type;
        logic [7:0]  byte_field;
        logic [7:0]  proto_number;
        logic [5:0]  ip_header_bytes;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic        last_in_frame;
    } t_rec;

    // Records produced by one input byte: one or two.
    typedef struct packed {
        logic two;
        t_rec rec1;
        t_rec rec0;
    } t_pair;

    function automatic t_rec mk_err(input logic [2:0] code, input logic [7:0] bf,
                                    input logic [5:0] ihb);
        t_rec r;
        r                 = '0;
        r.record          = REC_ERROR;
        r.error_code      = code;
        r.byte_field      = bf;
        r.ip_header_bytes = ihb;
        r.last_in_frame   = 1'b1;
        return r;
    endfunction

endpackage

@@ src/ehp_front.sv @@
`timescale 1ns / 1ps
// Front end: byte position tracking, header field capture and record generation.
// Depends on ehp_pkg.
module ehp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_data_byte,
    input  logic           i_frame_end,
    input  logic           i_full,
    output logic           o_stall,
    output logic           o_push,
    output ehp_pkg::t_pair o_pair
);

    logic [ehp_pkg::POS_W-1:0] r_pos, n_pos;
    logic                      r_fin, n_fin;
    logic [47:0] r_dmac, n_dmac, r_smac, n_smac;
    logic [15:0] r_etype, n_etype, r_tlen, n_tlen;
    logic [7:0]  r_vihl, n_vihl, r_ttl, n_ttl, r_proto, n_proto;
    logic [31:0] r_sip, n_sip, r_dip, n_dip;
    logic [15:0] r_sport, n_sport, r_dport, n_dport;
    logic [31:0] r_seq, n_seq, r_ack, n_ack;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_ulen, n_ulen;

    logic                      accept;
    logic [ehp_pkg::POS_W-1:0] cpos, tpos, off;
    logic [5:0]                ihb;
    logic [7:0]                c8, t8;
    logic                      has_a, has_b, has_c, has_d;
    logic                      fin_a, fin_b, fin_c;
    ehp_pkg::t_rec             rec_a, rec_b, rec_c, rec_d;
    logic [1:0]                cnt;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_pos = r_pos;     n_fin = r_fin;
        n_dmac = r_dmac;   n_smac = r_smac;   n_etype = r_etype; n_vihl = r_vihl;
        n_tlen = r_tlen;   n_ttl = r_ttl;     n_proto = r_proto;
        n_sip = r_sip;     n_dip = r_dip;     n_sport = r_sport; n_dport = r_dport;
        n_seq = r_seq;     n_ack = r_ack;     n_flags = r_flags; n_ulen = r_ulen;

        cpos = (r_pos < ehp_pkg::POS_MAX) ? r_pos + 7'd1 : r_pos;

        if (r_pos < 7'd6) begin
            n_dmac = {r_dmac[39:0], i_data_byte};
        end else if (r_pos < 7'd12) begin
            n_smac = {r_smac[39:0], i_data_byte};
        end else if (r_pos < 7'd14) begin
            n_etype = {r_etype[7:0], i_data_byte};
        end else if (r_pos == 7'd14) begin
            n_vihl = i_data_byte;
        end else if (r_pos == 7'd16 || r_pos == 7'd17) begin
            n_tlen = {r_tlen[7:0], i_data_byte};
        end else if (r_pos == 7'd22) begin
            n_ttl = i_data_byte;
        end else if (r_pos == 7'd23) begin
            n_proto = i_data_byte;
        end else if (r_pos >= 7'd26 && r_pos < 7'd30) begin
            n_sip = {r_sip[23:0], i_data_byte};
        end else if (r_pos >= 7'd30 && r_pos < 7'd34) begin
            n_dip = {r_dip[23:0], i_data_byte};
        end

        ihb  = {n_vihl[3:0], 2'b00};
        tpos = ehp_pkg::ETH_HDR_END + {1'b0, ihb};
        off  = r_pos - tpos;
        c8   = {1'b0, cpos};
        t8   = {1'b0, tpos};

        if (r_pos >= ehp_pkg::IP_HDR_END && ihb >= ehp_pkg::IP_HDR_MIN && r_pos >= tpos
            && r_pos < ehp_pkg::POS_MAX) begin
            if (off < 7'd2) begin
                n_sport = {r_sport[7:0], i_data_byte};
            end else if (off < 7'd4) begin
                n_dport = {r_dport[7:0], i_data_byte};
            end else if (n_proto == ehp_pkg::PROTO_TCP) begin
                if (off < 7'd8) begin
                    n_seq = {r_seq[23:0], i_data_byte};
                end else if (off < 7'd12) begin
                    n_ack = {r_ack[23:0], i_data_byte};
                end else if (off == 7'd13) begin
                    n_flags = i_data_byte;
                end
            end else if (n_proto == ehp_pkg::PROTO_UDP) begin
                if (off < 7'd6) begin
                    n_ulen = {r_ulen[7:0], i_data_byte};
                end
            end
        end

        // Ethernet record
        has_a                = (r_pos == ehp_pkg::ETH_HDR_END - 7'd1);
        rec_a                = '0;
        rec_a.record         = ehp_pkg::REC_ETH;
        rec_a.source_field   = n_smac;
        rec_a.dest_field     = n_dmac;
        rec_a.length_or_type = n_etype;
        rec_a.last_in_frame  = (n_etype != ehp_pkg::ETYPE_IPV4);
        fin_a                = has_a && rec_a.last_in_frame;

        // IPv4 record or version / IHL error
        has_b = !fin_a && (r_pos == ehp_pkg::IP_HDR_END - 7'd1);
        if (n_vihl[7:4] != ehp_pkg::IP_VERSION_4) begin
            rec_b = ehp_pkg::mk_err(ehp_pkg::ERR_BAD_VERSION, {4'd0, n_vihl[7:4]}, 6'd0);
        end else if (ihb < ehp_pkg::IP_HDR_MIN) begin
            rec_b = ehp_pkg::mk_err(ehp_pkg::ERR_BAD_IHL, 8'd0, ihb);
        end else begin
            rec_b                 = '0;
            rec_b.record          = ehp_pkg::REC_IPV4;
            rec_b.source_field    = {16'd0, n_sip};
            rec_b.dest_field      = {16'd0, n_dip};
            rec_b.length_or_type  = n_tlen;
            rec_b.byte_field      = n_ttl;
            rec_b.proto_number    = n_proto;
            rec_b.ip_header_bytes = ihb;
        end
        fin_b = fin_a || (has_b && rec_b.last_in_frame);

        // Transport record
        rec_c               = '0;
        rec_c.last_in_frame = 1'b1;
        if (n_proto == ehp_pkg::PROTO_TCP) begin
            has_c              = (c8 == t8 + ehp_pkg::TCP_HDR_LEN);
            rec_c.record       = ehp_pkg::REC_TCP;
            rec_c.source_field = {32'd0, n_sport};
            rec_c.dest_field   = {32'd0, n_dport};
            rec_c.byte_field   = n_flags;
            rec_c.seq_number   = n_seq;
            rec_c.ack_number   = n_ack;
        end else if (n_proto == ehp_pkg::PROTO_UDP) begin
            has_c                = (c8 == t8 + ehp_pkg::UDP_HDR_LEN);
            rec_c.record         = ehp_pkg::REC_UDP;
            rec_c.source_field   = {32'd0, n_sport};
            rec_c.dest_field     = {32'd0, n_dport};
            rec_c.length_or_type = n_ulen;
        end else begin
            has_c              = (c8 == t8);
            rec_c.record       = ehp_pkg::REC_OTHER;
            rec_c.proto_number = n_proto;
        end
        has_c = has_c && !fin_b && cpos >= ehp_pkg::IP_HDR_END
                && r_pos < ehp_pkg::POS_MAX;
        fin_c = fin_b || has_c;

        // Short frame error at the frame end
        has_d = i_frame_end && !fin_c;
        if (cpos < ehp_pkg::ETH_HDR_END) begin
            rec_d = ehp_pkg::mk_err(ehp_pkg::ERR_SHORT_ETH, 8'd0, 6'd0);
        end else if (cpos < ehp_pkg::IP_HDR_END) begin
            rec_d = ehp_pkg::mk_err(ehp_pkg::ERR_SHORT_IPV4, 8'd0, 6'd0);
        end else if (cpos < tpos) begin
            rec_d = ehp_pkg::mk_err(ehp_pkg::ERR_SHORT_IHL, 8'd0, 6'd0);
        end else if (n_proto == ehp_pkg::PROTO_TCP) begin
            rec_d = ehp_pkg::mk_err(ehp_pkg::ERR_SHORT_TCP, 8'd0, 6'd0);
        end else begin
            rec_d = ehp_pkg::mk_err(ehp_pkg::ERR_SHORT_UDP, 8'd0, 6'd0);
        end

        o_pair = '0;
        cnt    = 2'd0;
        if (has_a) begin
            o_pair.rec0 = rec_a;
            cnt         = 2'd1;
        end
        if (has_b) begin
            if (cnt == 2'd0) begin
                o_pair.rec0 = rec_b;
            end else begin
                o_pair.rec1 = rec_b;
            end
            cnt = cnt + 2'd1;
        end
        if (has_c) begin
            if (cnt == 2'd0) begin
                o_pair.rec0 = rec_c;
            end else begin
                o_pair.rec1 = rec_c;
            end
            cnt = cnt + 2'd1;
        end
        if (has_d) begin
            if (cnt == 2'd0) begin
                o_pair.rec0 = rec_d;
            end else begin
                o_pair.rec1 = rec_d;
            end
            cnt = cnt + 2'd1;
        end
        o_pair.two = (cnt == 2'd2);

        o_push = accept && !r_fin && (cnt != 2'd0);

        if (!accept || r_fin) begin
            n_dmac = r_dmac;   n_smac = r_smac;   n_etype = r_etype; n_vihl = r_vihl;
            n_tlen = r_tlen;   n_ttl = r_ttl;     n_proto = r_proto;
            n_sip = r_sip;     n_dip = r_dip;     n_sport = r_sport; n_dport = r_dport;
            n_seq = r_seq;     n_ack = r_ack;     n_flags = r_flags; n_ulen = r_ulen;
        end else begin
            n_pos = cpos;
            n_fin = fin_c || has_d;
        end
        if (accept && i_frame_end) begin
            n_pos = '0;
            n_fin = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;     r_fin <= 1'b0;
            r_dmac <= '0;    r_smac <= '0;    r_etype <= '0;  r_vihl <= '0;
            r_tlen <= '0;    r_ttl <= '0;     r_proto <= '0;
            r_sip <= '0;     r_dip <= '0;     r_sport <= '0;  r_dport <= '0;
            r_seq <= '0;     r_ack <= '0;     r_flags <= '0;  r_ulen <= '0;
        end else begin
            r_pos <= n_pos;     r_fin <= n_fin;
            r_dmac <= n_dmac;   r_smac <= n_smac;   r_etype <= n_etype; r_vihl <= n_vihl;
            r_tlen <= n_tlen;   r_ttl <= n_ttl;     r_proto <= n_proto;
            r_sip <= n_sip;     r_dip <= n_dip;     r_sport <= n_sport; r_dport <= n_dport;
            r_seq <= n_seq;     r_ack <= n_ack;     r_flags <= n_flags; r_ulen <= n_ulen;
        end
    end

endmodule

@@ src/ehp_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue of record pairs between the front end and the output stage.
// Depends on ehp_pkg.
module ehp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ehp_pkg::t_pair i_pair,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_nonempty,
    output ehp_pkg::t_pair o_head
);

    ehp_pkg::t_pair r_mem [2];
    logic           r_wr, n_wr, r_rd, n_rd;
    logic [1:0]     r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_head     = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr  = do_push ? ~r_wr : r_wr;
        n_rd  = do_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ src/ehp_back.sv @@
`timescale 1ns / 1ps
// Output stage: presents the queued records one item at a time.
// Depends on ehp_pkg.
module ehp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_nonempty,
    input  ehp_pkg::t_pair i_head,
    input  logic           i_stall,
    output logic           o_pop,
    output logic           o_valid,
    output ehp_pkg::t_rec  o_rec
);

    logic r_idx, n_idx;
    logic accept;

    assign o_valid = i_nonempty;
    assign o_rec   = r_idx ? i_head.rec1 : i_head.rec0;
    assign accept  = o_valid && !i_stall;
    assign o_pop   = accept && (r_idx || !i_head.two);

    always_comb begin
        n_idx = r_idx;
        if (accept) begin
            n_idx = !o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 1'b0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

@@ src/eth_ipv4_l4_header_parser.sv @@
`timescale 1ns / 1ps
// Ethernet/IPv4/TCP/UDP header parser, top level. Depends on ehp_pkg, ehp_front,
// ehp_queue and ehp_back.
// Throughput: one byte per cycle; the input stalls only while the two-entry queue is full.
// Records are registered in the two-entry queue once the byte that completes them is accepted;
// a second record from the same byte is presented after the first one is taken.
// Reset (synchronous, active low) clears byte position, frame state, captured fields and queue.
module eth_ipv4_l4_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_record,
    output logic [2:0]  o_error_code,
    output logic [47:0] o_source_field,
    output logic [47:0] o_dest_field,
    output logic [15:0] o_length_or_type,
    output logic [7:0]  o_byte_field,
    output logic [7:0]  o_proto_number,
    output logic [5:0]  o_ip_header_bytes,
    output logic [31:0] o_seq_number,
    output logic [31:0] o_ack_number,
    output logic        o_last_in_frame
);

    logic           push, pop, full, nonempty;
    ehp_pkg::t_pair pair, head;
    ehp_pkg::t_rec  rec;

    ehp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .i_full      (full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_pair      (pair)
    );

    ehp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pair     (pair),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    ehp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_head     (head),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_rec      (rec)
    );

    assign o_record          = rec.record;
    assign o_error_code      = rec.error_code;
    assign o_source_field    = rec.source_field;
    assign o_dest_field      = rec.dest_field;
    assign o_length_or_type  = rec.length_or_type;
    assign o_byte_field      = rec.byte_field;
    assign o_proto_number    = rec.proto_number;
    assign o_ip_header_bytes = rec.ip_header_bytes;
    assign o_seq_number      = rec.seq_number;
    assign o_ack_number      = rec.ack_number;
    assign o_last_in_frame   = rec.last_in_frame;

endmodule
